// ----- rtl/jsrd_pkg.sv -----
// jsrd_pkg: shared constants and types for the release-date sorter
// no dependencies; used by jsrd_cell and job_sort_by_release_date_top
package jsrd_pkg;

    localparam int MAX_JOBS   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int FIELD_W    = 32;
    localparam int TDATA_W    = 2 * FIELD_W;

    // one stored job
    typedef struct packed {
        logic                  valid;
        logic [DATA_WIDTH-1:0] key;
        logic [DATA_WIDTH-1:0] val;
    } t_entry;

    // chain-wide control, same for every cell
    typedef struct packed {
        logic                  insert;
        logic                  shift;
        logic [DATA_WIDTH-1:0] new_key;
        logic [DATA_WIDTH-1:0] new_val;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

// ----- rtl/jsrd_cell.sv -----
// jsrd_cell: one slot of the insertion chain, holds a single key/value pair
// depends on jsrd_pkg
module jsrd_cell
    import jsrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_left,
    input  logic      i_left_gt,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_gt
);

    t_entry r_entry;
    t_entry n_entry;

    // empty slot counts as larger than any key, ties stay ahead of the new job
    assign o_gt    = !r_entry.valid || (r_entry.key > i_ctl.new_key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_entry = i_right;
        end else if (i_ctl.insert && o_gt) begin
            if (i_left_gt) begin
                n_entry = i_left;
            end else begin
                n_entry.valid = 1'b1;
                n_entry.key   = i_ctl.new_key;
                n_entry.val   = i_ctl.new_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.key <= n_entry.key;
        r_entry.val <= n_entry.val;
    end

endmodule

// ----- rtl/job_sort_by_release_date_top.sv -----
// job_sort_by_release_date_top: insertion-chain sorter of jobs by release date
// depends on jsrd_pkg and jsrd_cell
//
// channel   dir  handshake                     payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata={processing_time,release_date}, tlast
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata={proc_time_res,release_date_res},
//                                              tlast=last_res, tuser=overflow
//
// filling: one job per cycle, each cell compares against the new key in parallel
// draining: one sorted job per cycle out of cell 0 while m_axis is ready and the chain shifts down,
// so a batch of n held jobs gives n output transfers; no input is taken meanwhile
// m_axis stalls simply hold the chain; reset empties all cells
module job_sort_by_release_date_top
    import jsrd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,  // [31:0] release_date, [63:32] processing_time
    input  logic               i_s_axis_tlast,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,  // [31:0] release_date_res, [63:32] proc_time_res
    output logic               o_m_axis_tlast,
    output logic               o_m_axis_tuser   // [0] overflow
);

    t_state    r_state;
    t_state    n_state;
    logic      r_ovf;
    logic      n_ovf;
    t_cell_ctl w_ctl;
    t_entry    w_ent [MAX_JOBS];
    logic      w_gt  [MAX_JOBS];
    t_entry    w_empty;
    logic      w_in_hs;
    logic      w_out_hs;
    logic      w_full;

    assign w_empty  = '0;
    assign w_full   = w_ent[MAX_JOBS-1].valid;
    assign w_in_hs  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_hs = o_m_axis_tvalid && i_m_axis_tready;

    assign o_s_axis_tready = (r_state == ST_FILL);
    assign o_m_axis_tvalid = (r_state == ST_DRAIN);
    assign o_m_axis_tdata  = {FIELD_W'(w_ent[0].val), FIELD_W'(w_ent[0].key)};
    assign o_m_axis_tlast  = !w_ent[1].valid;
    assign o_m_axis_tuser  = r_ovf;

    always_comb begin
        w_ctl.insert  = w_in_hs && !w_full;
        w_ctl.shift   = w_out_hs;
        w_ctl.new_key = DATA_WIDTH'(i_s_axis_tdata[FIELD_W-1:0]);
        w_ctl.new_val = DATA_WIDTH'(i_s_axis_tdata[TDATA_W-1:FIELD_W]);
    end

    genvar g;
    generate
        for (g = 0; g < MAX_JOBS; g++) begin : g_cell
            if (g == 0) begin : g_head
                jsrd_cell u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (w_ctl),
                    .i_left    (w_empty),
                    .i_left_gt (1'b0),
                    .i_right   (w_ent[g+1]),
                    .o_entry   (w_ent[g]),
                    .o_gt      (w_gt[g])
                );
            end else if (g == MAX_JOBS - 1) begin : g_tail
                jsrd_cell u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (w_ctl),
                    .i_left    (w_ent[g-1]),
                    .i_left_gt (w_gt[g-1]),
                    .i_right   (w_empty),
                    .o_entry   (w_ent[g]),
                    .o_gt      (w_gt[g])
                );
            end else begin : g_mid
                jsrd_cell u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (w_ctl),
                    .i_left    (w_ent[g-1]),
                    .i_left_gt (w_gt[g-1]),
                    .i_right   (w_ent[g+1]),
                    .o_entry   (w_ent[g]),
                    .o_gt      (w_gt[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        case (r_state)
            ST_FILL: begin
                if (w_in_hs) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_hs && o_m_axis_tlast) begin
                    n_state = ST_FILL;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_FILL;
                n_ovf   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

    // a drain always has a job at the head
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> w_ent[0].valid)
        else $error("drain with empty head cell");

    // after the final result the chain is empty again
    a_empty_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_hs && o_m_axis_tlast) |=> (!w_ent[0].valid && !r_ovf))
        else $error("chain not empty after final transaction");

    // overflow only rises when a job arrives at a full chain
    a_ovf_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> $past(w_in_hs && w_full))
        else $error("overflow without a dropped job");

    // head pair stays in order with its neighbor
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ent[0].valid && w_ent[1].valid) |-> (w_ent[0].key <= w_ent[1].key))
        else $error("head cells out of order");

endmodule
